[rtl/core/etp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_pkg: shared types and constants of the escape-time pixel engine
// Q24.40 fixed-point helpers, register indexes, command codes and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package etp_pkg;

  typedef logic signed [63:0] fix_t;

  localparam int PIX_W      = 12;
  localparam int FRAC_BITS  = 40;
  localparam int GRAY_N     = 60;

  localparam fix_t S64_MAX     = {1'b0, {63{1'b1}}};
  localparam fix_t S64_MIN     = {1'b1, {63{1'b0}}};
  localparam fix_t Q_ONE       = 64'sh0000_0100_0000_0000;
  localparam fix_t Q_HALF      = 64'sh0000_0080_0000_0000;
  localparam fix_t Q_QUARTER   = 64'sh0000_0040_0000_0000;
  localparam fix_t Q_MINUS_TWO = 64'shFFFF_FE00_0000_0000;
  localparam fix_t Q_FEIG      = -64'sd1540586214816;

  // register indexes
  localparam logic [2:0] CFG_X_MIN    = 3'd0;
  localparam logic [2:0] CFG_Y_MAX    = 3'd1;
  localparam logic [2:0] CFG_STEP_X   = 3'd2;
  localparam logic [2:0] CFG_STEP_Y   = 3'd3;
  localparam logic [2:0] CFG_MAP_MODE = 3'd4;
  localparam logic [2:0] CFG_FAMILY   = 3'd5;
  localparam logic [2:0] CFG_ITER_MAX = 3'd6;
  localparam logic [2:0] CFG_RADIUS   = 3'd7;

  // reset values
  localparam fix_t        RST_X_MIN  = -64'sd4123168604160;
  localparam fix_t        RST_Y_MAX  = 64'sd1649267441664;
  localparam logic [62:0] RST_STEP_X = 63'd33151104355;
  localparam logic [62:0] RST_STEP_Y = 63'd33318534175;
  localparam logic [15:0] RST_ITER   = 16'd10000;
  localparam logic [62:0] RST_RADIUS = 63'd4398046511104000000;

  // plane transforms
  localparam logic [2:0] MODE_IDENT   = 3'd0;
  localparam logic [2:0] MODE_RECIP   = 3'd1;
  localparam logic [2:0] MODE_QUARTER = 3'd2;
  localparam logic [2:0] MODE_FEIG    = 3'd3;
  localparam logic [2:0] MODE_MTWO    = 3'd4;
  localparam logic [2:0] MODE_ONE     = 3'd5;

  // multiply operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_CX   = 4'd1;
  localparam logic [3:0] OP_CY   = 4'd2;
  localparam logic [3:0] OP_DX   = 4'd3;
  localparam logic [3:0] OP_DY   = 4'd4;
  localparam logic [3:0] OP_UR   = 4'd5;
  localparam logic [3:0] OP_UI   = 4'd6;
  localparam logic [3:0] OP_P    = 4'd7;
  localparam logic [3:0] OP_CZR  = 4'd8;
  localparam logic [3:0] OP_CIZI = 4'd9;
  localparam logic [3:0] OP_CRZI = 4'd10;
  localparam logic [3:0] OP_CIZR = 4'd11;
  localparam logic [3:0] OP_TWR  = 4'd12;
  localparam logic [3:0] OP_TIWI = 4'd13;
  localparam logic [3:0] OP_TRWI = 4'd14;
  localparam logic [3:0] OP_TIWR = 4'd15;

  // datapath actions
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_LOAD       = 4'd1;
  localparam logic [3:0] ACT_IDENT      = 4'd2;
  localparam logic [3:0] ACT_SET_ZERO   = 4'd3;
  localparam logic [3:0] ACT_NORM_INIT  = 4'd4;
  localparam logic [3:0] ACT_NORM_SHIFT = 4'd5;
  localparam logic [3:0] ACT_RECIP      = 4'd6;
  localparam logic [3:0] ACT_MAP        = 4'd7;
  localparam logic [3:0] ACT_INIT       = 4'd8;
  localparam logic [3:0] ACT_SET_ESC    = 4'd9;
  localparam logic [3:0] ACT_QUPD1      = 4'd10;
  localparam logic [3:0] ACT_QUPD2      = 4'd11;
  localparam logic [3:0] ACT_LMID       = 4'd12;
  localparam logic [3:0] ACT_LUPD       = 4'd13;

  typedef struct packed {
    logic [3:0] act;
    logic [3:0] op;
    logic       mul_go;
    logic       div_go;
    logic       out_load;
  } etp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic recip_mode;
    logic p_zero;
    logic norm_big;
    logic limit;
    logic esc;
    logic family;
  } etp_status_t;

  typedef logic [7:0] gray_lut_t [GRAY_N];

  function automatic gray_lut_t gray_lut_build();
    gray_lut_t t;
    for (int i = 0; i < GRAY_N; i++) begin
      t[i] = 8'(255 - (i * 255 + 59) / 60);
    end
    return t;
  endfunction

  localparam gray_lut_t GRAY_LUT = gray_lut_build();

  function automatic logic [63:0] mag64(fix_t a);
    logic [63:0] u;
    u = a;
    return a[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic fix_t sat_neg(fix_t a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic fix_t from_mag(logic [63:0] m, logic neg);
    if (!neg) return m[63] ? S64_MAX : m;
    if (m[63]) return S64_MIN;
    return ~m + 64'd1;
  endfunction

  // product of magnitudes, shifted down by the fraction and saturated
  function automatic fix_t fmul_res(logic [127:0] p, logic neg);
    if (p[127:104] != '0) return neg ? S64_MIN : S64_MAX;
    return from_mag(p[103:40], neg);
  endfunction

  function automatic logic [63:0] usq_res(logic [127:0] p);
    if (p[127:104] != '0) return '1;
    return p[103:40];
  endfunction

  // base +/- idx*step on the offset-binary view of base
  function automatic fix_t coord_res(fix_t base, logic [127:0] p, logic add);
    logic [63:0] b;
    logic [64:0] s;
    b = base ^ S64_MIN;
    if (add) begin
      s = {1'b0, b} + {1'b0, p[63:0]};
      if (p[127:64] != '0 || s[64]) return S64_MAX;
    end else begin
      if (p[127:64] != '0 || p[63:0] > b) return S64_MIN;
      s = {1'b0, b} - {1'b0, p[63:0]};
    end
    return s[63:0] ^ S64_MIN;
  endfunction

endpackage

[rtl/core/etp_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_mul: 64x64 unsigned multiplier
// Four 32x32 partial products, one per cycle, registered and then summed
// into a 128-bit accumulator. done pulses when the product is ready.
// ----------------------------------------------------------------------------
module etp_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_r, b_r, pp_r;
  logic [127:0] acc_r;
  logic [1:0]   sh_r;
  logic [2:0]   cnt_r;
  logic         run_r, pv_r, done_r;
  logic [31:0]  ah, bh;
  logic         start;

  assign start = go && !run_r;
  assign ah    = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign bh    = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  assign prod  = acc_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && cnt_r[2];
      pv_r   <= run_r && !cnt_r[2];
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r[2]) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + (128'(pp_r) << {sh_r, 5'd0});
    end
    if (run_r && !cnt_r[2]) begin
      pp_r <= 64'(ah) * 64'(bh);
      sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    end
  end

endmodule

[rtl/core/etp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_div: restoring divider for the reciprocal
// Quotient of (v << k) / d over 128 dividend bits, one bit per cycle,
// saturated to the positive 64-bit range.
// ----------------------------------------------------------------------------
module etp_div
  import etp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [30:0] v,
  input  logic [6:0]  k,
  input  logic [62:0] d,
  output logic [63:0] q,
  output logic        done
);

  logic [31:0] v_r;
  logic [6:0]  k_r, i_r;
  logic [62:0] d_r, rem_r, rem_nxt;
  logic [63:0] q_r, rem2;
  logic        ovf_r, run_r, done_r, bit_in, ge, start;
  logic [7:0]  j;

  assign start = go && !run_r;
  // dividend bit i is v[i-k] when that index lands inside v
  assign j      = {1'b0, i_r} - {1'b0, k_r};
  assign bit_in = !j[7] && (j[6:5] == 2'b00) && v_r[j[4:0]];
  assign rem2   = {rem_r, bit_in};
  assign ge     = rem2 >= {1'b0, d_r};
  assign rem_nxt = ge ? 63'(rem2 - {1'b0, d_r}) : rem2[62:0];
  assign q      = (ovf_r || q_r[63]) ? 64'(S64_MAX) : q_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= run_r && (i_r == '0);
      if (start) begin
        run_r <= 1'b1;
        i_r   <= '1;
      end else if (run_r) begin
        i_r <= i_r - 7'd1;
        if (i_r == '0) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {1'b0, v};
      k_r   <= k;
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[62:0], ge};
      ovf_r <= ovf_r | q_r[63];
    end
  end

endmodule

[rtl/core/etp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_dp: escape-time datapath
// Configuration registers, plane point, reciprocal, orbit registers, the
// shared multiplier and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module etp_dp
  import etp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  logic [PIX_W-1:0] in_pixel_x,
  input  logic [PIX_W-1:0] in_pixel_y,
  input  etp_cmd_t         cmd,
  output etp_status_t      status,
  output logic [7:0]       out_gray_level,
  output logic [15:0]      out_iterations,
  output logic             out_escaped,
  output logic             out_zero_parameter
);

  localparam logic [PIX_W-1:0] CMASK =
    (COORD_BITS >= PIX_W) ? '1 : PIX_W'((1 << COORD_BITS) - 1);

  fix_t        x_min_r, y_max_r;
  logic [62:0] step_x_r, step_y_r, radius_r;
  logic [2:0]  map_mode_r;
  logic        family_r;
  logic [15:0] iter_max_r;

  logic [PIX_W-1:0] idx_x_r, idx_y_r;
  fix_t        px_r, py_r, cr_r, ci_r, zr_r, zi_r;
  fix_t        f0_r, f1_r, f2_r, f3_r, t0_r, t1_r, w0_r, w1_r;
  fix_t        rr_r, ri_r;
  logic [63:0] ax_r, ay_r, ur_r, ui_r;
  logic [62:0] d_r;
  logic [5:0]  s_r;
  logic [15:0] n_r;
  logic        esc_r, zero_r;

  logic [7:0]  gray_r;
  logic [15:0] iter_r;
  logic        esc_out_r, zero_out_r;

  fix_t         sa, sb, fres;
  logic         neg;
  logic [127:0] prod;
  logic         mul_done, dx_done, dy_done;
  logic [63:0]  qx, qy;
  logic [64:0]  m2s;
  logic [63:0]  m2;
  logic [7:0]   gray_nxt;
  logic [6:0]   kshift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= RST_X_MIN;
      y_max_r    <= RST_Y_MAX;
      step_x_r   <= RST_STEP_X;
      step_y_r   <= RST_STEP_Y;
      map_mode_r <= MODE_IDENT;
      family_r   <= 1'b0;
      iter_max_r <= RST_ITER;
      radius_r   <= RST_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_MIN:    x_min_r    <= cfg_wdata;
        CFG_Y_MAX:    y_max_r    <= cfg_wdata;
        CFG_STEP_X:   step_x_r   <= cfg_wdata[62:0];
        CFG_STEP_Y:   step_y_r   <= cfg_wdata[62:0];
        CFG_MAP_MODE: map_mode_r <= cfg_wdata[2:0];
        CFG_FAMILY:   family_r   <= cfg_wdata[0];
        CFG_ITER_MAX: iter_max_r <= cfg_wdata[15:0];
        CFG_RADIUS:   radius_r   <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      OP_CX:   begin sa = {{(64-PIX_W){1'b0}}, idx_x_r}; sb = {1'b0, step_x_r}; end
      OP_CY:   begin sa = {{(64-PIX_W){1'b0}}, idx_y_r}; sb = {1'b0, step_y_r}; end
      OP_DX:   begin sa = ax_r; sb = ax_r; end
      OP_DY:   begin sa = ay_r; sb = ay_r; end
      OP_UR:   begin sa = zr_r; sb = zr_r; end
      OP_UI:   begin sa = zi_r; sb = zi_r; end
      OP_P:    begin sa = zr_r; sb = zi_r; end
      OP_CZR:  begin sa = cr_r; sb = zr_r; end
      OP_CIZI: begin sa = ci_r; sb = zi_r; end
      OP_CRZI: begin sa = cr_r; sb = zi_r; end
      OP_CIZR: begin sa = ci_r; sb = zr_r; end
      OP_TWR:  begin sa = t0_r; sb = w0_r; end
      OP_TIWI: begin sa = t1_r; sb = w1_r; end
      OP_TRWI: begin sa = t0_r; sb = w1_r; end
      OP_TIWR: begin sa = t1_r; sb = w0_r; end
      default: begin sa = '0; sb = '0; end
    endcase
  end

  assign neg = sa[63] ^ sb[63];

  etp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mag64(sa)),
    .b     (mag64(sb)),
    .prod  (prod),
    .done  (mul_done)
  );

  assign fres   = fmul_res(prod, neg);
  assign kshift = 7'(2 * FRAC_BITS) - {1'b0, s_r};

  etp_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .v     (ax_r[30:0]),
    .k     (kshift),
    .d     (d_r),
    .q     (qx),
    .done  (dx_done)
  );

  etp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .v     (ay_r[30:0]),
    .k     (kshift),
    .d     (d_r),
    .q     (qy),
    .done  (dy_done)
  );

  // |z|^2 saturated to the unsigned range
  assign m2s = {1'b0, ur_r} + {1'b0, ui_r};
  assign m2  = m2s[64] ? '1 : m2s[63:0];

  always_comb begin
    status.mul_done   = mul_done;
    status.div_done   = dx_done && dy_done;
    status.recip_mode = (map_mode_r >= MODE_RECIP) && (map_mode_r <= MODE_ONE);
    status.p_zero     = (px_r == '0) && (py_r == '0);
    status.norm_big   = (ax_r[63:31] | ay_r[63:31]) != '0;
    status.limit      = n_r >= iter_max_r;
    status.esc        = m2 > {1'b0, radius_r};
    status.family     = family_r;
  end

  // multiplier results
  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.op)
        OP_CX:   px_r <= coord_res(x_min_r, prod, 1'b1);
        OP_CY:   py_r <= coord_res(y_max_r, prod, 1'b0);
        OP_DX:   d_r  <= prod[62:0];
        OP_DY:   d_r  <= d_r + prod[62:0];
        OP_UR:   ur_r <= usq_res(prod);
        OP_UI:   ui_r <= usq_res(prod);
        OP_P, OP_CZR, OP_TWR:    f0_r <= fres;
        OP_CIZI, OP_TIWI:        f1_r <= fres;
        OP_CRZI, OP_TRWI:        f2_r <= fres;
        OP_CIZR, OP_TIWR:        f3_r <= fres;
        default: ;
      endcase
    end
  end

  // sequenced actions
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LOAD: begin
        idx_x_r <= in_pixel_x & CMASK;
        idx_y_r <= in_pixel_y & CMASK;
        n_r     <= '0;
        esc_r   <= 1'b0;
        zero_r  <= 1'b0;
      end
      ACT_IDENT: begin
        cr_r <= px_r;
        ci_r <= py_r;
      end
      ACT_SET_ZERO: zero_r <= 1'b1;
      ACT_NORM_INIT: begin
        ax_r <= mag64(px_r);
        ay_r <= mag64(py_r);
        s_r  <= '0;
      end
      ACT_NORM_SHIFT: begin
        ax_r <= ax_r >> 1;
        ay_r <= ay_r >> 1;
        s_r  <= s_r + 6'd1;
      end
      ACT_RECIP: begin
        rr_r <= from_mag(qx, px_r[63]);
        ri_r <= from_mag(qy, !py_r[63] && (py_r != '0));
      end
      ACT_MAP: begin
        case (map_mode_r)
          MODE_RECIP:   begin cr_r <= rr_r; ci_r <= ri_r; end
          MODE_QUARTER: begin cr_r <= sat_add(Q_QUARTER, rr_r); ci_r <= ri_r; end
          MODE_FEIG:    begin cr_r <= sat_sub(Q_FEIG, rr_r); ci_r <= sat_neg(ri_r); end
          MODE_MTWO:    begin cr_r <= sat_add(Q_MINUS_TWO, rr_r); ci_r <= ri_r; end
          default:      begin cr_r <= sat_add(Q_ONE, rr_r); ci_r <= ri_r; end
        endcase
      end
      ACT_INIT: begin
        zr_r <= family_r ? Q_HALF : '0;
        zi_r <= '0;
        n_r  <= '0;
      end
      ACT_SET_ESC: esc_r <= 1'b1;
      ACT_QUPD1: begin
        // squares as signed values: saturate the unsigned form
        t0_r <= sat_sub(ur_r[63] ? S64_MAX : ur_r, ui_r[63] ? S64_MAX : ui_r);
        t1_r <= sat_add(f0_r, f0_r);
      end
      ACT_QUPD2: begin
        zr_r <= sat_add(t0_r, cr_r);
        zi_r <= sat_add(t1_r, ci_r);
        n_r  <= n_r + 16'd1;
      end
      ACT_LMID: begin
        t0_r <= sat_sub(f0_r, f1_r);
        t1_r <= sat_add(f2_r, f3_r);
        w0_r <= sat_sub(Q_ONE, zr_r);
        w1_r <= sat_neg(zi_r);
      end
      ACT_LUPD: begin
        zr_r <= sat_sub(f0_r, f1_r);
        zi_r <= sat_add(f2_r, f3_r);
        n_r  <= n_r + 16'd1;
      end
      default: ;
    endcase
  end

  assign gray_nxt = (esc_r && (n_r < 16'(GRAY_N))) ? GRAY_LUT[n_r[5:0]] : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gray_r     <= gray_nxt;
      iter_r     <= n_r;
      esc_out_r  <= esc_r;
      zero_out_r <= zero_r;
    end
  end

  assign out_gray_level     = gray_r;
  assign out_iterations     = iter_r;
  assign out_escaped        = esc_out_r;
  assign out_zero_parameter = zero_out_r;

endmodule

[rtl/core/etp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_ctrl: escape-time sequencer
// Walks one pixel through mapping, reciprocal and orbit iteration, issuing
// multiplier and divider runs, and owns both handshakes.
// ----------------------------------------------------------------------------
module etp_ctrl
  import etp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  etp_status_t status,
  output etp_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CX    = 5'd1;
  localparam logic [4:0] S_CY    = 5'd2;
  localparam logic [4:0] S_CHKZ  = 5'd3;
  localparam logic [4:0] S_NORM  = 5'd4;
  localparam logic [4:0] S_DX    = 5'd5;
  localparam logic [4:0] S_DY    = 5'd6;
  localparam logic [4:0] S_DIV   = 5'd7;
  localparam logic [4:0] S_RECIP = 5'd8;
  localparam logic [4:0] S_MAP   = 5'd9;
  localparam logic [4:0] S_INIT  = 5'd10;
  localparam logic [4:0] S_CHK   = 5'd11;
  localparam logic [4:0] S_UR    = 5'd12;
  localparam logic [4:0] S_UI    = 5'd13;
  localparam logic [4:0] S_ESC   = 5'd14;
  localparam logic [4:0] S_P     = 5'd15;
  localparam logic [4:0] S_Q1    = 5'd16;
  localparam logic [4:0] S_Q2    = 5'd17;
  localparam logic [4:0] S_L1    = 5'd18;
  localparam logic [4:0] S_L2    = 5'd19;
  localparam logic [4:0] S_L3    = 5'd20;
  localparam logic [4:0] S_L4    = 5'd21;
  localparam logic [4:0] S_L5    = 5'd22;
  localparam logic [4:0] S_L6    = 5'd23;
  localparam logic [4:0] S_L7    = 5'd24;
  localparam logic [4:0] S_L8    = 5'd25;
  localparam logic [4:0] S_L9    = 5'd26;
  localparam logic [4:0] S_L10   = 5'd27;
  localparam logic [4:0] S_DONE  = 5'd28;

  logic [4:0] state_r, state_nxt, tgt;
  logic       busy_r, busy_nxt, out_valid_r, out_valid_nxt;
  logic       is_mul, is_div;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    is_mul        = 1'b0;
    is_div        = 1'b0;
    tgt           = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = S_CX;
        end
      end
      S_CX: begin is_mul = 1'b1; cmd.op = OP_CX; tgt = S_CY; end
      S_CY: begin is_mul = 1'b1; cmd.op = OP_CY; tgt = S_CHKZ; end
      S_CHKZ: begin
        if (!status.recip_mode) begin
          cmd.act   = ACT_IDENT;
          state_nxt = S_INIT;
        end else if (status.p_zero) begin
          cmd.act   = ACT_SET_ZERO;
          state_nxt = S_DONE;
        end else begin
          cmd.act   = ACT_NORM_INIT;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // bring both magnitudes under 31 bits
        if (status.norm_big) cmd.act = ACT_NORM_SHIFT;
        else state_nxt = S_DX;
      end
      S_DX:  begin is_mul = 1'b1; cmd.op = OP_DX; tgt = S_DY; end
      S_DY:  begin is_mul = 1'b1; cmd.op = OP_DY; tgt = S_DIV; end
      S_DIV: begin is_div = 1'b1; tgt = S_RECIP; end
      S_RECIP: begin cmd.act = ACT_RECIP; state_nxt = S_MAP; end
      S_MAP:   begin cmd.act = ACT_MAP; state_nxt = S_INIT; end
      S_INIT:  begin cmd.act = ACT_INIT; state_nxt = S_CHK; end
      S_CHK:   state_nxt = status.limit ? S_DONE : S_UR;
      S_UR:  begin is_mul = 1'b1; cmd.op = OP_UR; tgt = S_UI; end
      S_UI:  begin is_mul = 1'b1; cmd.op = OP_UI; tgt = S_ESC; end
      S_ESC: begin
        if (status.esc) begin
          cmd.act   = ACT_SET_ESC;
          state_nxt = S_DONE;
        end else begin
          state_nxt = status.family ? S_L1 : S_P;
        end
      end
      S_P:   begin is_mul = 1'b1; cmd.op = OP_P; tgt = S_Q1; end
      S_Q1:  begin cmd.act = ACT_QUPD1; state_nxt = S_Q2; end
      S_Q2:  begin cmd.act = ACT_QUPD2; state_nxt = S_CHK; end
      S_L1:  begin is_mul = 1'b1; cmd.op = OP_CZR;  tgt = S_L2; end
      S_L2:  begin is_mul = 1'b1; cmd.op = OP_CIZI; tgt = S_L3; end
      S_L3:  begin is_mul = 1'b1; cmd.op = OP_CRZI; tgt = S_L4; end
      S_L4:  begin is_mul = 1'b1; cmd.op = OP_CIZR; tgt = S_L5; end
      S_L5:  begin cmd.act = ACT_LMID; state_nxt = S_L6; end
      S_L6:  begin is_mul = 1'b1; cmd.op = OP_TWR;  tgt = S_L7; end
      S_L7:  begin is_mul = 1'b1; cmd.op = OP_TIWI; tgt = S_L8; end
      S_L8:  begin is_mul = 1'b1; cmd.op = OP_TRWI; tgt = S_L9; end
      S_L9:  begin is_mul = 1'b1; cmd.op = OP_TIWR; tgt = S_L10; end
      S_L10: begin cmd.act = ACT_LUPD; state_nxt = S_CHK; end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // launch a unit once per state, move on when it reports done
    if (is_mul) begin
      if (!busy_r) begin
        cmd.mul_go = 1'b1;
        busy_nxt   = 1'b1;
      end else if (status.mul_done) begin
        busy_nxt  = 1'b0;
        state_nxt = tgt;
      end
    end
    if (is_div) begin
      if (!busy_r) begin
        cmd.div_go = 1'b1;
        busy_nxt   = 1'b1;
      end else if (status.div_done) begin
        busy_nxt  = 1'b0;
        state_nxt = tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/escape_time_parameter_plane_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_parameter_plane_pixel: escape-time engine for one pixel
// Maps a pixel to a Q24.40 plane point, applies the selected transform and
// iterates the quadratic or logistic map until escape or the limit.
// ----------------------------------------------------------------------------
// One pixel is processed at a time; a finished result waits in the output
// register while the next pixel is taken. All products run on one shared
// 32x32 multiplier, four partial products per 64-bit product. A pixel
// passes through mapping, then, in the reciprocal modes, normalizing, the
// divisor and the bit-serial dividers; then the quadratic or logistic
// iterations and the last escape test.
module escape_time_parameter_plane_pixel
  import etp_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel_x,
  input  logic [PIX_W-1:0] in_pixel_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_gray_level,
  output logic [15:0]      out_iterations,
  output logic             out_escaped,
  output logic             out_zero_parameter,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_wdata
);

  etp_cmd_t    cmd;
  etp_status_t status;

  etp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  etp_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .cmd                (cmd),
    .status             (status),
    .out_gray_level     (out_gray_level),
    .out_iterations     (out_iterations),
    .out_escaped        (out_escaped),
    .out_zero_parameter (out_zero_parameter)
  );

endmodule

[rtl/core/etp_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_chk: port-level checks for the escape-time engine
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module etp_chk
  import etp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [7:0]       out_gray_level,
  input logic [15:0]      out_iterations,
  input logic             out_escaped,
  input logic             out_zero_parameter
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iterations)
      && $stable(out_gray_level) && $stable(out_escaped))
    else $error("result changed while stalled");

  // one pixel in flight: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a pixel is in flight");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_parameter |-> !out_escaped && out_iterations == 16'd0
      && out_gray_level == 8'd0)
    else $error("zero parameter result not interior");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_escaped |-> out_gray_level == 8'd0)
    else $error("interior point with nonzero gray");

endmodule

bind escape_time_parameter_plane_pixel etp_chk u_etp_chk (.*);

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for escape_time_parameter_plane_pixel
// Walks a table of directed pixels over several register settings, then
// random pixels over random windows, transforms and families. Each result
// transfer is checked against its typed row or a Q24.40 escape-time predictor.
// ----------------------------------------------------------------------------
module tb;
  import etp_pkg::*;

  localparam int  LIMIT       = 3_000_000;
  localparam int  MAX_REPORTS = 10;
  localparam int  RAND_PHASES = 6;
  localparam int  RAND_PIXELS = 16;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic FAM_QUAD     = 1'b0;
  localparam logic FAM_LOGISTIC = 1'b1;
  localparam fix_t Q_FOUR = 64'sh0000_0400_0000_0000;

  typedef struct packed {
    logic [7:0]  gray;
    logic [15:0] iters;
    logic        esc;
    logic        zp;
  } pixel_res_t;

  typedef struct {
    int          ph;
    logic [11:0] x;
    logic [11:0] y;
    bit          typed;
    pixel_res_t  r;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_gray_level;
  logic [15:0] out_iterations;
  logic        out_escaped;
  logic        out_zero_parameter;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // register shadow
  fix_t        sh_x_min, sh_y_max;
  logic [62:0] sh_step_x, sh_step_y, sh_radius;
  logic [2:0]  sh_mode;
  logic        sh_family;
  logic [15:0] sh_iter_max;

  pixel_res_t  pending_pixels[$];
  pixel_row_t  dir_rows[$];
  bit          row_typed = 1'b0;
  pixel_res_t  row_exp = '0;
  bit          quiet = 1'b0;
  int          cycles = 0;
  int          mismatches = 0;
  int          results = 0;
  int          sent = 0;
  int          escapes = 0;

  escape_time_parameter_plane_pixel dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel_x, .in_pixel_y,
    .out_valid, .out_ready, .out_gray_level, .out_iterations, .out_escaped,
    .out_zero_parameter, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] abs64(fix_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic fix_t signed_of(logic [63:0] m, logic neg);
    if (!neg) return m[63] ? S64_MAX : fix_t'(m);
    if (m[63]) return S64_MIN;
    return -fix_t'(m);
  endfunction

  function automatic fix_t clamp66(logic signed [65:0] e);
    if (e > 66'sd9223372036854775807) return S64_MAX;
    if (e < -66'sd9223372036854775808) return S64_MIN;
    return e[63:0];
  endfunction

  function automatic fix_t plus(fix_t a, fix_t b);
    return clamp66(66'(a) + 66'(b));
  endfunction

  function automatic fix_t minus(fix_t a, fix_t b);
    return clamp66(66'(a) - 66'(b));
  endfunction

  function automatic fix_t negate(fix_t a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic fix_t qmul(fix_t a, fix_t b);
    logic [127:0] p;
    logic         neg;
    p   = 128'(abs64(a)) * 128'(abs64(b));
    neg = a[63] ^ b[63];
    if (p[127:104] != '0) return neg ? S64_MIN : S64_MAX;
    return signed_of(p[103:40], neg);
  endfunction

  function automatic logic [63:0] qsquare(logic [63:0] m);
    logic [127:0] p;
    p = 128'(m) * 128'(m);
    if (p[127:104] != '0) return '1;
    return p[103:40];
  endfunction

  function automatic void cplx_mul(fix_t ar, fix_t ai, fix_t br, fix_t bi,
                                   output fix_t rr, output fix_t ri);
    rr = minus(qmul(ar, br), qmul(ai, bi));
    ri = plus(qmul(ar, bi), qmul(ai, br));
  endfunction

  // exact base +/- idx*step, then saturated
  function automatic fix_t plane_coord(fix_t base, logic [11:0] idx,
                                       logic [62:0] step, bit add);
    logic signed [129:0] e;
    logic [127:0]        p;
    p = 128'(idx) * 128'(step);
    e = add ? 130'(base) + $signed({2'b0, p}) : 130'(base) - $signed({2'b0, p});
    if (e > 130'sd9223372036854775807) return S64_MAX;
    if (e < -130'sd9223372036854775808) return S64_MIN;
    return e[63:0];
  endfunction

  function automatic logic [63:0] recip_mag(logic [63:0] v, int k, logic [63:0] d);
    logic [127:0] q;
    q = (128'(v) << k) / 128'(d);
    return (q > 128'(S64_MAX)) ? 64'(S64_MAX) : q[63:0];
  endfunction

  function automatic void reciprocal(fix_t x, fix_t y, output fix_t rr, output fix_t ri);
    logic [63:0] ax, ay, m, d;
    int          len, sh;
    ax  = abs64(x);
    ay  = abs64(y);
    m   = (ax > ay) ? ax : ay;
    len = 0;
    while (len < 64 && (m >> len) != 0) len++;
    sh = (len > 31) ? len - 31 : 0;
    ax = ax >> sh;
    ay = ay >> sh;
    d  = ax * ax + ay * ay;
    rr = signed_of(recip_mag(ax, 2 * FRAC_BITS - sh, d), x[63]);
    ri = signed_of(recip_mag(ay, 2 * FRAC_BITS - sh, d), !y[63] && y != 0);
  endfunction

  function automatic pixel_res_t escape_pixel(logic [11:0] pxi, logic [11:0] pyi);
    pixel_res_t  r;
    fix_t        px, py, cr, ci, zr, zi, rr, ri, nr, tr, ti;
    logic [63:0] a, b, m2;
    logic [64:0] sum;
    int          n, k;
    r  = '0;
    px = plane_coord(sh_x_min, pxi, sh_step_x, 1'b1);
    py = plane_coord(sh_y_max, pyi, sh_step_y, 1'b0);
    cr = px;
    ci = py;
    if (sh_mode >= MODE_RECIP && sh_mode <= MODE_ONE) begin
      if (px == 0 && py == 0) begin
        r.zp = 1'b1;
        return r;
      end
      reciprocal(px, py, rr, ri);
      ci = ri;
      case (sh_mode)
        MODE_RECIP:   cr = rr;
        MODE_QUARTER: cr = plus(Q_QUARTER, rr);
        MODE_FEIG: begin
          cr = minus(Q_FEIG, rr);
          ci = negate(ri);
        end
        MODE_MTWO:    cr = plus(Q_MINUS_TWO, rr);
        default:      cr = plus(Q_ONE, rr);
      endcase
    end
    zr = sh_family ? Q_HALF : '0;
    zi = '0;
    for (n = 0; n < sh_iter_max; n++) begin
      a   = qsquare(abs64(zr));
      b   = qsquare(abs64(zi));
      sum = 65'(a) + 65'(b);
      m2  = sum[64] ? '1 : sum[63:0];
      if (m2 > 64'(sh_radius)) begin
        r.esc = 1'b1;
        break;
      end
      if (sh_family == FAM_QUAD) begin
        nr = plus(minus(qmul(zr, zr), qmul(zi, zi)), cr);
        zi = plus(plus(qmul(zr, zi), qmul(zr, zi)), ci);
        zr = nr;
      end else begin
        cplx_mul(cr, ci, zr, zi, tr, ti);
        cplx_mul(tr, ti, minus(Q_ONE, zr), negate(zi), zr, zi);
      end
    end
    r.iters = n[15:0];
    if (r.esc) begin
      k = (n * 255 + 59) / 60;
      r.gray = (k >= 255) ? 8'd0 : 8'(255 - k);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_X_MIN:    sh_x_min    = val;
      CFG_Y_MAX:    sh_y_max    = val;
      CFG_STEP_X:   sh_step_x   = val[62:0];
      CFG_STEP_Y:   sh_step_y   = val[62:0];
      CFG_MAP_MODE: sh_mode     = val[2:0];
      CFG_FAMILY:   sh_family   = val[0];
      CFG_ITER_MAX: sh_iter_max = val[15:0];
      default:      sh_radius   = val[62:0];
    endcase
  endtask

  task automatic load_regs(fix_t xm, fix_t ym, logic [63:0] sx, logic [63:0] sy,
                           logic [2:0] mode, logic fam, logic [15:0] lim,
                           logic [63:0] rad);
    reg_write(CFG_X_MIN, xm);
    reg_write(CFG_Y_MAX, ym);
    reg_write(CFG_STEP_X, sx);
    reg_write(CFG_STEP_Y, sy);
    reg_write(CFG_MAP_MODE, 64'(mode));
    reg_write(CFG_FAMILY, 64'(fam));
    reg_write(CFG_ITER_MAX, 64'(lim));
    reg_write(CFG_RADIUS, rad);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_regs(int ph);
    fix_t sixteenth;
    sixteenth = Q_ONE >>> 4;
    case (ph)
      1: load_regs(0, 0, sixteenth, sixteenth, MODE_RECIP, FAM_QUAD, 20, Q_FOUR);
      2: load_regs(0, 0, sixteenth, sixteenth, MODE_SPARE6, FAM_QUAD, 20, Q_FOUR);
      3: load_regs(0, 0, sixteenth, sixteenth, MODE_SPARE7, FAM_LOGISTIC, 20, Q_FOUR);
      4: load_regs(-Q_ONE, Q_ONE, sixteenth, sixteenth, MODE_IDENT, FAM_QUAD, 0, Q_FOUR);
      5: load_regs(S64_MAX, S64_MIN, 64'(S64_MAX), 64'(S64_MAX), MODE_IDENT, FAM_QUAD,
                   20, 64'(S64_MAX));
      6: load_regs(-Q_ONE, Q_ONE, sixteenth, sixteenth, MODE_QUARTER, FAM_LOGISTIC,
                   30, Q_FOUR);
      7: load_regs(-Q_ONE, Q_ONE, sixteenth, sixteenth, MODE_FEIG, FAM_LOGISTIC,
                   30, Q_FOUR);
      8: load_regs(-Q_ONE, Q_ONE, sixteenth, sixteenth, MODE_MTWO, FAM_QUAD, 30, Q_FOUR);
      9: load_regs(-Q_ONE, Q_ONE, sixteenth, sixteenth, MODE_ONE, FAM_QUAD, 30, Q_FOUR);
      10: load_regs(Q_ONE, 0, sixteenth, sixteenth, MODE_IDENT, FAM_QUAD, 16'hFFFF, 0);
      default: load_regs(Q_QUARTER + 64'sd67108864, 0, 0, 0, MODE_IDENT, FAM_QUAD,
                         1000, Q_FOUR);
    endcase
  endtask

  task automatic random_regs();
    logic [2:0]  mode;
    logic        fam;
    logic [15:0] lim;
    mode = 3'($urandom_range(0, 7));
    fam  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      // whole register range, kept short since most orbits leave at once
      load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, mode, fam, 16'($urandom_range(1, 8)),
                {$urandom, $urandom});
    end else begin
      lim = fam ? 16'($urandom_range(1, 24)) : 16'($urandom_range(1, 64));
      load_regs(Q_MINUS_TWO + (fix_t'($urandom_range(0, 2048)) - 1024) * 64'sd1073741824,
                Q_ONE + fix_t'($urandom_range(0, 1 << 30)),
                64'($urandom_range(1 << 28, 1 << 30)),
                64'($urandom_range(1 << 28, 1 << 30)),
                mode, fam, lim, ($urandom_range(0, 7) == 0) ? 64'($urandom) : Q_FOUR);
    end
  endtask

  // ---------------------------------------------------------------- traffic
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit typed, pixel_res_t r);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    row_typed  <= typed;
    row_exp    <= r;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  // block is idle once every pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_row(int ph, int x, int y, bit typed, pixel_res_t r);
    pixel_row_t row;
    row = '{ph, 12'(x), 12'(y), typed, r};
    dir_rows.push_back(row);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (row_typed) pending_pixels.push_back(row_exp);
      else pending_pixels.push_back(escape_pixel(in_pixel_x, in_pixel_y));
    end
  end

  always @(posedge clk) begin
    pixel_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: gray %0d iters %0d", out_gray_level,
                   out_iterations);
      end else begin
        e = pending_pixels.pop_front();
        if (e.esc) escapes++;
        if (out_gray_level !== e.gray || out_iterations !== e.iters ||
            out_escaped !== e.esc || out_zero_parameter !== e.zp) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp gray %0d iters %0d esc %0b zp %0b, got %0d %0d %0b %0b",
                     e.gray, e.iters, e.esc, e.zp, out_gray_level, out_iterations,
                     out_escaped, out_zero_parameter);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    pixel_res_t interior, none, zero_pt, first_out;
    int         ph;
    sh_x_min    = RST_X_MIN;
    sh_y_max    = RST_Y_MAX;
    sh_step_x   = RST_STEP_X;
    sh_step_y   = RST_STEP_Y;
    sh_mode     = MODE_IDENT;
    sh_family   = FAM_QUAD;
    sh_iter_max = RST_ITER;
    sh_radius   = RST_RADIUS;
    interior    = '{8'd0, 16'd20, 1'b0, 1'b0};
    none        = '0;
    zero_pt     = '{8'd0, 16'd0, 1'b0, 1'b1};
    first_out   = '{8'd250, 16'd1, 1'b1, 1'b0};

    add_row(0, 0, 0, 0, none);
    add_row(0, 4095, 4095, 0, none);
    add_row(0, 0, 4095, 0, none);
    add_row(0, 4095, 0, 0, none);
    add_row(1, 0, 0, 1, zero_pt);
    add_row(1, 16, 0, 0, none);
    add_row(1, 4095, 4095, 0, none);
    add_row(2, 0, 0, 1, interior);
    add_row(3, 0, 0, 0, none);
    add_row(3, 5, 9, 0, none);
    add_row(4, 5, 9, 1, none);
    add_row(4, 4095, 0, 1, none);
    add_row(5, 0, 0, 1, first_out);
    add_row(5, 4095, 4095, 1, first_out);
    add_row(6, 3, 40, 0, none);
    add_row(6, 4095, 4095, 0, none);
    add_row(7, 10, 20, 0, none);
    add_row(7, 1234, 2345, 0, none);
    add_row(8, 16, 16, 0, none);
    add_row(8, 2730, 1365, 0, none);
    add_row(9, 20, 4, 0, none);
    add_row(10, 0, 0, 1, first_out);
    add_row(10, 4095, 4095, 1, first_out);
    add_row(11, 0, 0, 0, none);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ph = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].ph != ph) begin
        drain();
        ph = dir_rows[i].ph;
        quiet = (ph % 4 == 3);
        directed_regs(ph);
      end
      send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].r);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      random_regs();
      for (int i = 0; i < RAND_PIXELS; i++)
        send_pixel(12'($urandom), 12'($urandom), 0, none);
    end

    drain();
    $display("%0d pixels sent over %0d register settings, %0d results, %0d escaped",
             sent, RAND_PHASES + 12, results, escapes);
    $display("mismatches %0d, still waiting %0d", mismatches, pending_pixels.size());
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
